// ===== src/dprs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the drain pump retry sequencer.
// No dependencies; imported by every module of the block.
package dprs_pkg;

	localparam int ADC_BITS = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_ON_TICKS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REST_TICKS        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RETRY_ON_TICKS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TRIP_THRESHOLD    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_THRESHOLD    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_FILTER_TICKS = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TRIP_FILTER_TICKS = 3'd7;

	// register defaults after reset
	localparam logic [15:0]         RST_FIRST_ON_TICKS    = 16'd900;
	localparam logic [15:0]         RST_REST_TICKS        = 16'd60;
	localparam logic [15:0]         RST_RETRY_ON_TICKS    = 16'd120;
	localparam logic [5:0]          RST_RETRY_LIMIT       = 6'd44;
	localparam logic [ADC_BITS-1:0] RST_TRIP_THRESHOLD    = ADC_BITS'(40);
	localparam logic [ADC_BITS-1:0] RST_IDLE_THRESHOLD    = ADC_BITS'(175);
	localparam logic [7:0]          RST_IDLE_FILTER_TICKS = 8'd5;
	localparam logic [7:0]          RST_TRIP_FILTER_TICKS = 8'd5;

	typedef struct packed {
		logic [15:0]         first_on_ticks;
		logic [15:0]         rest_ticks;
		logic [15:0]         retry_on_ticks;
		logic [5:0]          retry_limit;
		logic [ADC_BITS-1:0] trip_threshold;
		logic [ADC_BITS-1:0] idle_threshold;
		logic [7:0]          idle_filter_ticks;
		logic [7:0]          trip_filter_ticks;
	} cfg_t;

	typedef struct packed {
		logic                run_request;
		logic                restart_sequence;
		logic [ADC_BITS-1:0] current_sample;
	} in_item_t;

	typedef struct packed {
		logic       motor_enable;
		logic       load_seen;
		logic       trip_seen;
		logic       fault_flag;
		logic       run_active;
		logic [5:0] phase_number;
	} out_item_t;

endpackage

// ===== src/dprs_cfg.sv =====
`timescale 1ns / 1ps
// Configuration register file of the drain pump retry sequencer.
// Depends on dprs_pkg for the register indexes, defaults and cfg_t.
module dprs_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write_en,
	input  logic [dprs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dprs_pkg::CFG_DATA_W-1:0]   cfg_data,
	output dprs_pkg::cfg_t                    cfg
);
	import dprs_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_on_ticks    <= RST_FIRST_ON_TICKS;
			cfg_q.rest_ticks        <= RST_REST_TICKS;
			cfg_q.retry_on_ticks    <= RST_RETRY_ON_TICKS;
			cfg_q.retry_limit       <= RST_RETRY_LIMIT;
			cfg_q.trip_threshold    <= RST_TRIP_THRESHOLD;
			cfg_q.idle_threshold    <= RST_IDLE_THRESHOLD;
			cfg_q.idle_filter_ticks <= RST_IDLE_FILTER_TICKS;
			cfg_q.trip_filter_ticks <= RST_TRIP_FILTER_TICKS;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_FIRST_ON_TICKS:    cfg_q.first_on_ticks    <= cfg_data[15:0];
				REG_REST_TICKS:        cfg_q.rest_ticks        <= cfg_data[15:0];
				REG_RETRY_ON_TICKS:    cfg_q.retry_on_ticks    <= cfg_data[15:0];
				REG_RETRY_LIMIT:       cfg_q.retry_limit       <= cfg_data[5:0];
				REG_TRIP_THRESHOLD:    cfg_q.trip_threshold    <= cfg_data[ADC_BITS-1:0];
				REG_IDLE_THRESHOLD:    cfg_q.idle_threshold    <= cfg_data[ADC_BITS-1:0];
				REG_IDLE_FILTER_TICKS: cfg_q.idle_filter_ticks <= cfg_data[7:0];
				REG_TRIP_FILTER_TICKS: cfg_q.trip_filter_ticks <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/dprs_step.sv =====
`timescale 1ns / 1ps
// Sequencer state and its one-tick update: phase timing, retry fault and
// current filters. Depends on dprs_pkg for cfg_t, in_item_t and out_item_t.
module dprs_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  dprs_pkg::cfg_t      cfg,
	input  dprs_pkg::in_item_t  item,
	output dprs_pkg::out_item_t result
);
	import dprs_pkg::*;

	logic        run_flag_q;
	logic [5:0]  phase_index_q;
	logic        phase_is_on_q;
	logic [15:0] phase_countdown_q;
	logic        fault_q;
	logic        load_flag_q;
	logic [7:0]  load_countdown_q;
	logic        trip_flag_q;
	logic [7:0]  trip_countdown_q;
	logic        drive_q;

	logic        run_d;
	logic [5:0]  index_d;
	logic        is_on_d;
	logic [15:0] countdown_d;
	logic        fault_d;
	logic        load_flag_d;
	logic [7:0]  load_cnt_d;
	logic        trip_flag_d;
	logic [7:0]  trip_cnt_d;
	logic        drive_d;
	logic        trip_pre;
	logic [7:0]  trip_cnt_pre;
	logic [7:0]  load_cnt_dec;
	logic [5:0]  index_in;

	always_comb begin
		index_in = item.restart_sequence ? 6'd0 : phase_index_q;
		run_d       = item.run_request;
		is_on_d     = item.run_request ? phase_is_on_q : 1'b0;
		index_d     = item.run_request ? index_in : 6'd0;
		countdown_d = item.run_request ? phase_countdown_q : 16'd0;
		fault_d     = fault_q;
		load_flag_d = load_flag_q;
		load_cnt_d  = load_countdown_q;
		trip_flag_d = trip_flag_q;
		trip_cnt_d  = trip_countdown_q;
		drive_d     = drive_q;
		trip_pre     = trip_flag_q;
		trip_cnt_pre = trip_countdown_q;
		load_cnt_dec = load_countdown_q;

		if (!run_d || fault_q) begin
			// stopped or faulted: drive off, re-arm both filters
			drive_d     = 1'b0;
			load_flag_d = 1'b1;
			load_cnt_d  = cfg.idle_filter_ticks;
			trip_flag_d = 1'b1;
			trip_cnt_d  = cfg.trip_filter_ticks;
		end else if (countdown_d == 16'd0) begin
			// phase load tick: drive and filters hold
			is_on_d = ~index_d[0];
			if (index_d == 6'd0)
				countdown_d = cfg.first_on_ticks;
			else
				countdown_d = is_on_d ? cfg.retry_on_ticks : cfg.rest_ticks;
			index_d = 6'(index_d + 6'd1);
			if (index_d > cfg.retry_limit)
				fault_d = 1'b1;
		end else begin
			countdown_d = 16'(countdown_d - 16'd1);
			if (is_on_d) begin
				// a pending trip forces one off tick
				if (trip_flag_q) begin
					trip_pre     = 1'b0;
					trip_cnt_pre = cfg.trip_filter_ticks;
					drive_d      = 1'b0;
				end else begin
					drive_d = 1'b1;
				end
				if (item.current_sample < cfg.trip_threshold) begin
					if (trip_cnt_pre != 8'd0) begin
						trip_cnt_d  = 8'(trip_cnt_pre - 8'd1);
						trip_flag_d = trip_pre;
					end else begin
						trip_cnt_d  = trip_cnt_pre;
						trip_flag_d = 1'b1;
					end
				end else begin
					trip_flag_d = 1'b0;
					trip_cnt_d  = cfg.trip_filter_ticks;
				end
				if (item.current_sample < cfg.idle_threshold) begin
					if (load_countdown_q != 8'd0)
						load_cnt_dec = 8'(load_countdown_q - 8'd1);
					load_cnt_d = load_cnt_dec;
					if (load_cnt_dec == 8'd0)
						load_flag_d = 1'b0;
				end else begin
					load_flag_d = 1'b1;
					load_cnt_d  = cfg.idle_filter_ticks;
				end
			end else begin
				drive_d     = 1'b0;
				load_flag_d = 1'b1;
				load_cnt_d  = cfg.idle_filter_ticks;
				trip_flag_d = 1'b1;
				trip_cnt_d  = cfg.trip_filter_ticks;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_flag_q        <= 1'b0;
			phase_index_q     <= 6'd0;
			phase_is_on_q     <= 1'b0;
			phase_countdown_q <= 16'd0;
			fault_q           <= 1'b0;
			load_flag_q       <= 1'b0;
			load_countdown_q  <= RST_IDLE_FILTER_TICKS;
			trip_flag_q       <= 1'b0;
			trip_countdown_q  <= RST_TRIP_FILTER_TICKS;
			drive_q           <= 1'b0;
		end else if (step_en) begin
			run_flag_q        <= run_d;
			phase_index_q     <= index_d;
			phase_is_on_q     <= is_on_d;
			phase_countdown_q <= countdown_d;
			fault_q           <= fault_d;
			load_flag_q       <= load_flag_d;
			load_countdown_q  <= load_cnt_d;
			trip_flag_q       <= trip_flag_d;
			trip_countdown_q  <= trip_cnt_d;
			drive_q           <= drive_d;
		end
	end

	always_comb begin
		result.motor_enable = drive_d;
		result.load_seen    = load_flag_d;
		result.trip_seen    = trip_flag_d;
		result.fault_flag   = fault_d;
		result.run_active   = run_d;
		result.phase_number = index_d;
	end

endmodule

// ===== src/drain_pump_retry_sequencer.sv =====
`timescale 1ns / 1ps
// Drain pump retry sequencer: one control tick in, one status result out.
// Channels: in_valid/in_stall/in_data carries a tick (run_request,
// restart_sequence, current_sample); out_valid/out_stall/out_data carries
// the drive and status flags of that tick. A transfer happens at a clock
// edge with valid high and stall low.
// A tick taken is held in the input register; its result is written to the
// output register when that register frees up, and shows then.
// Throughput: one tick per cycle while not stalled; the whole phase, fault and
// filter update is one short compare-and-count path between the two registers.
// When the receiver stalls, the result holds and the input register keeps
// one waiting tick; in_stall rises only when both are full.
// Configuration: cfg_write_en, cfg_index, cfg_data write registers 0..7
// and are meant to be used only while no tick is in flight.
// Reset (arst_n low): config returns to defaults, the sequence stops with
// the drive off, both registers drop their contents.
// Depends on dprs_pkg, dprs_cfg and dprs_step.
module drain_pump_retry_sequencer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  dprs_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output dprs_pkg::out_item_t             out_data,
	input  logic                            cfg_write_en,
	input  logic [dprs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dprs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dprs_pkg::*;

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result;
	out_item_t out_data_q;
	logic      out_valid_q;
	logic      advance;
	logic      in_take;

	// move the held tick forward when the result register frees up
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	dprs_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cfg          (cfg)
	);

	dprs_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.cfg     (cfg),
		.item    (item_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take)
			item_s1 <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_data_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== tb/sv/drain_pump_retry_sequencer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for drain_pump_retry_sequencer: random and directed ticks,
// a tick-by-tick status predictor and an in-order result scoreboard.
// Depends on dprs_pkg and the drain_pump_retry_sequencer RTL only.
module drain_pump_retry_sequencer_tb;
	import dprs_pkg::*;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_style_e;

	// Predicts the status word of every accepted tick and checks results in order.
	class pump_status_board;
		cfg_t        regs;
		bit          run_on;
		bit [5:0]    phase_idx;
		bit          in_on_phase;
		bit [15:0]   phase_left;
		bit          faulted;
		bit          load_f;
		bit [7:0]    load_left;
		bit          trip_f;
		bit [7:0]    trip_left;
		bit          drive;
		out_item_t   expected_status[$];
		int          errors;

		function new();
			regs.first_on_ticks    = RST_FIRST_ON_TICKS;
			regs.rest_ticks        = RST_REST_TICKS;
			regs.retry_on_ticks    = RST_RETRY_ON_TICKS;
			regs.retry_limit       = RST_RETRY_LIMIT;
			regs.trip_threshold    = RST_TRIP_THRESHOLD;
			regs.idle_threshold    = RST_IDLE_THRESHOLD;
			regs.idle_filter_ticks = RST_IDLE_FILTER_TICKS;
			regs.trip_filter_ticks = RST_TRIP_FILTER_TICKS;
			run_on      = 0;
			phase_idx   = '0;
			in_on_phase = 0;
			phase_left  = '0;
			faulted     = 0;
			load_f      = 0;
			load_left   = RST_IDLE_FILTER_TICKS;
			trip_f      = 0;
			trip_left   = RST_TRIP_FILTER_TICKS;
			drive       = 0;
			errors      = 0;
		endfunction

		function int pending();
			return expected_status.size();
		endfunction

		function void rearm();
			load_f    = 1;
			load_left = regs.idle_filter_ticks;
			trip_f    = 1;
			trip_left = regs.trip_filter_ticks;
		endfunction

		function void filter_current(logic [ADC_BITS-1:0] sample);
			if (sample < regs.trip_threshold) begin
				if (trip_left != 0)
					trip_left = trip_left - 8'd1;
				else
					trip_f = 1;
			end else begin
				trip_f    = 0;
				trip_left = regs.trip_filter_ticks;
			end
			if (sample < regs.idle_threshold) begin
				if (load_left != 0)
					load_left = load_left - 8'd1;
				if (load_left == 0)
					load_f = 0;
			end else begin
				load_f    = 1;
				load_left = regs.idle_filter_ticks;
			end
		endfunction

		function void note_tick(in_item_t t);
			out_item_t want;
			if (t.restart_sequence)
				phase_idx = '0;
			if (t.run_request) begin
				run_on = 1;
			end else begin
				run_on      = 0;
				in_on_phase = 0;
				phase_idx   = '0;
				phase_left  = '0;
			end
			if (!run_on || faulted) begin
				drive = 0;
				rearm();
			end else if (phase_left == 0) begin
				// load the next phase; drive and filters hold
				in_on_phase = ~phase_idx[0];
				if (phase_idx == 0)
					phase_left = regs.first_on_ticks;
				else
					phase_left = in_on_phase ? regs.retry_on_ticks : regs.rest_ticks;
				phase_idx = phase_idx + 6'd1;
				if (phase_idx > regs.retry_limit)
					faulted = 1;
			end else begin
				phase_left = phase_left - 16'd1;
				if (in_on_phase) begin
					// a pending trip drops the drive for this tick
					if (trip_f) begin
						trip_f    = 0;
						trip_left = regs.trip_filter_ticks;
						drive     = 0;
					end else begin
						drive = 1;
					end
					filter_current(t.current_sample);
				end else begin
					drive = 0;
					rearm();
				end
			end
			want.motor_enable = drive;
			want.load_seen    = load_f;
			want.trip_seen    = trip_f;
			want.fault_flag   = faulted;
			want.run_active   = run_on;
			want.phase_number = phase_idx;
			expected_status.push_back(want);
		endfunction

		function void check_status(out_item_t got);
			out_item_t want;
			if (expected_status.size() == 0) begin
				$error("result with no tick pending: %h", got);
				errors++;
				return;
			end
			want = expected_status.pop_front();
			if (got.motor_enable !== want.motor_enable) begin
				$error("motor_enable: expected %0d, got %0d", want.motor_enable, got.motor_enable);
				errors++;
			end
			if (got.load_seen !== want.load_seen) begin
				$error("load_seen: expected %0d, got %0d", want.load_seen, got.load_seen);
				errors++;
			end
			if (got.trip_seen !== want.trip_seen) begin
				$error("trip_seen: expected %0d, got %0d", want.trip_seen, got.trip_seen);
				errors++;
			end
			if (got.fault_flag !== want.fault_flag) begin
				$error("fault_flag: expected %0d, got %0d", want.fault_flag, got.fault_flag);
				errors++;
			end
			if (got.run_active !== want.run_active) begin
				$error("run_active: expected %0d, got %0d", want.run_active, got.run_active);
				errors++;
			end
			if (got.phase_number !== want.phase_number) begin
				$error("phase_number: expected %0d, got %0d", want.phase_number,
					got.phase_number);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_data;
	logic                  cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	pump_status_board sb = new();
	idle_style_e      idle_mode = IDLE_NONE;
	int               sent_total = 0;
	int               sample_regime = 3;

	drain_pump_retry_sequencer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (idle_mode == IDLE_RECEIVER)
			out_stall <= ($urandom_range(99) < 76);
		else if (idle_mode == IDLE_BOTH)
			out_stall <= ($urandom_range(99) < 12);
		else
			out_stall <= 1'b0;
	end

	// sample both channels with pre-edge values
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_tick(in_data);
		if (arst_n && out_valid && !out_stall)
			sb.check_status(out_data);
	end

	function automatic in_item_t mk_tick(bit run, bit restart, int sample);
		in_item_t t;
		t.run_request      = run;
		t.restart_sequence = restart;
		t.current_sample   = ADC_BITS'(sample);
		return t;
	endfunction

	function automatic cfg_t make_cfg(int first_on, int rest, int retry_on, int limit,
			int trip, int idle, int idle_f, int trip_f);
		cfg_t c;
		c.first_on_ticks    = 16'(first_on);
		c.rest_ticks        = 16'(rest);
		c.retry_on_ticks    = 16'(retry_on);
		c.retry_limit       = 6'(limit);
		c.trip_threshold    = ADC_BITS'(trip);
		c.idle_threshold    = ADC_BITS'(idle);
		c.idle_filter_ticks = 8'(idle_f);
		c.trip_filter_ticks = 8'(trip_f);
		return c;
	endfunction

	// Current readings come in stretches so the filters can actually count down.
	function automatic int pick_sample();
		int top;
		int trip;
		int idle;
		int pick;
		top  = (1 << ADC_BITS) - 1;
		trip = int'(sb.regs.trip_threshold);
		idle = int'(sb.regs.idle_threshold);
		if ($urandom_range(7) == 0)
			sample_regime = $urandom_range(4);
		case (sample_regime)
			0: begin
				return (trip == 0) ? 0 : $urandom_range(trip - 1, 0);
			end
			1: begin
				return (idle <= trip) ? $urandom_range(top, 0) : $urandom_range(idle - 1, trip);
			end
			2: begin
				return $urandom_range(top, (idle > trip) ? idle : trip);
			end
			4: begin
				pick = $urandom_range(5);
				case (pick)
					0: return (trip > 0) ? trip - 1 : 0;
					1: return trip;
					2: return (idle > 0) ? idle - 1 : 0;
					3: return idle;
					4: return 0;
					default: return top;
				endcase
			end
			default: begin
				return $urandom_range(top, 0);
			end
		endcase
	endfunction

	// Mostly a held run command with rare stops and restarts.
	function automatic in_item_t random_tick();
		bit run;
		bit restart;
		run     = ($urandom_range(99) >= 4);
		restart = ($urandom_range(99) < 3);
		return mk_tick(run, restart, pick_sample());
	endfunction

	task automatic send_tick(input in_item_t t);
		int gap_pct;
		gap_pct = (idle_mode == IDLE_SENDER) ? 76 : (idle_mode == IDLE_BOTH) ? 12 : 0;
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (sb.pending() != 0);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= val;
		@(posedge clk);
	endtask

	task automatic apply_settings(input cfg_t c);
		drain_results();
		repeat (4) @(posedge clk);
		put_reg(REG_FIRST_ON_TICKS, c.first_on_ticks);
		put_reg(REG_REST_TICKS, c.rest_ticks);
		put_reg(REG_RETRY_ON_TICKS, c.retry_on_ticks);
		put_reg(REG_RETRY_LIMIT, CFG_DATA_W'(c.retry_limit));
		put_reg(REG_TRIP_THRESHOLD, CFG_DATA_W'(c.trip_threshold));
		put_reg(REG_IDLE_THRESHOLD, CFG_DATA_W'(c.idle_threshold));
		put_reg(REG_IDLE_FILTER_TICKS, CFG_DATA_W'(c.idle_filter_ticks));
		put_reg(REG_TRIP_FILTER_TICKS, CFG_DATA_W'(c.trip_filter_ticks));
		cfg_write_en <= 1'b0;
		sb.regs = c;
	endtask

	task automatic run_random(input int count, input int pause_at);
		for (int i = 0; i < count; i++) begin
			if (i == pause_at)
				drain_results();
			send_tick(random_tick());
			sent_total++;
			idle_mode = idle_style_e'((sent_total / 90) % 4);
		end
	endtask

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: stop, start, trip and no-load filtering, restart mid-phase
		send_tick(mk_tick(0, 0, 0));
		send_tick(mk_tick(0, 1, 1023));
		send_tick(mk_tick(1, 0, 0));
		send_tick(mk_tick(1, 0, 1023));
		for (int i = 0; i < 7; i++)
			send_tick(mk_tick(1, 0, 0));
		send_tick(mk_tick(1, 0, 39));
		send_tick(mk_tick(1, 0, 40));
		send_tick(mk_tick(1, 0, 174));
		send_tick(mk_tick(1, 0, 175));
		send_tick(mk_tick(1, 1, 500));
		send_tick(mk_tick(0, 0, 0));
		send_tick(mk_tick(1, 1, 1023));
		send_tick(mk_tick(1, 0, 512));
		send_tick(mk_tick(1, 0, 1023));
		send_tick(mk_tick(0, 0, 341));

		// longest phases and widest filters, a retry limit of 1
		apply_settings(make_cfg(65535, 65535, 65535, 1, 1023, 1023, 255, 255));
		run_random(60, -1);

		// zero-length phases load every tick; a limit of 63 lets the index wrap
		apply_settings(make_cfg(0, 0, 0, 63, 0, 0, 0, 0));
		run_random(150, -1);

		apply_settings(make_cfg(5, 3, 6, 63, 300, 600, 3, 2));
		run_random(450, 200);

		apply_settings(make_cfg(1, 1, 2, 63, 512, 1023, 0, 1));
		run_random(350, -1);

		apply_settings(make_cfg($urandom_range(12, 1), $urandom_range(8, 1),
			$urandom_range(12, 1), 63, $urandom_range(1023, 0), $urandom_range(1023, 0),
			$urandom_range(6, 0), $urandom_range(6, 0)));
		run_random(400, -1);

		// the fault is sticky, so the run that exhausts retries comes last
		apply_settings(make_cfg(3, 2, 3, 12, 200, 700, 2, 1));
		run_random(320, -1);

		drain_results();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
src/dprs_pkg.sv
src/dprs_cfg.sv
src/dprs_step.sv
src/drain_pump_retry_sequencer.sv
tb/sv/drain_pump_retry_sequencer_tb.sv
